// ----- rtl/att_pkg.sv -----
`timescale 1ns / 1ps

package att_pkg;

    localparam int SLOTS_DEFAULT = 32;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_REMOVE   = 2'd1;
    localparam logic [1:0] ACT_SNAPSHOT = 2'd2;
    localparam logic [1:0] ACT_HWM      = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [63:0] TS_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] handle;
        logic [63:0] read_ts;
        logic [63:0] global_id;
        logic [63:0] bound;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] txn_id;
        logic [63:0] ts_value;
        logic        empty_res;
        logic        last;
    } out_item_t;

endpackage

// ----- rtl/att_slot_store.sv -----
`timescale 1ns / 1ps

module att_slot_store
    import att_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic             rd_valid,
    output logic [15:0]      rd_handle,
    output logic [63:0]      rd_ts,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [15:0]      wr_handle,
    input  logic [63:0]      wr_ts,
    input  logic             clr_en,
    input  logic [IDX_W-1:0] clr_idx
);

    logic [SLOTS-1:0] valid_reg;
    logic [15:0]      handle_mem [0:SLOTS-1];
    logic [63:0]      ts_mem     [0:SLOTS-1];
    logic             rd_valid_reg;
    logic [15:0]      rd_handle_reg;
    logic [63:0]      rd_ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_en) begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            handle_mem[wr_idx] <= wr_handle;
            ts_mem[wr_idx]     <= wr_ts;
        end
        if (rd_en) begin
            rd_valid_reg  <= valid_reg[rd_idx];
            rd_handle_reg <= handle_mem[rd_idx];
            rd_ts_reg     <= ts_mem[rd_idx];
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_handle = rd_handle_reg;
    assign rd_ts     = rd_ts_reg;

endmodule

// ----- rtl/active_transaction_table_top.sv -----
// Insert, remove and high water mark give their result after one pass over all SLOTS slots.
// Snapshot with n qualifying slots makes n passes, one result per pass (one empty result if n is 0).
// A result held by a low m_ready delays the loading of the next result until it is taken.
// Throughput: one item at a time; s_ready is low from transfer until the last result is loaded.
// Every pass walks the slot memory one entry per cycle through a single compare path.
// Reset (aresetn low, synchronous) clears all slot valid bits at once; no clearing pass.
`timescale 1ns / 1ps

module active_transaction_table_top
    import att_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    in_item_t         in_reg, in_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] eidx_reg, eidx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [63:0]      best_v_reg, best_v_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]      prev_v_reg, prev_v_next;
    logic [IDX_W-1:0] prev_idx_reg, prev_idx_next;
    logic             first_reg, first_next;
    out_item_t        out_reg, out_next;
    logic             m_valid_reg, m_valid_next;

    logic             rd_en;
    logic             rd_valid;
    logic [15:0]      rd_handle;
    logic [63:0]      rd_ts;
    logic             wr_en;
    logic             clr_en;
    logic             qual;
    logic             out_free;

    att_slot_store #(
        .SLOTS(SLOTS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rd_en),
        .rd_idx    (scan_reg[IDX_W-1:0]),
        .rd_valid  (rd_valid),
        .rd_handle (rd_handle),
        .rd_ts     (rd_ts),
        .wr_en     (wr_en),
        .wr_idx    (best_idx_reg),
        .wr_handle (in_reg.handle),
        .wr_ts     (in_reg.read_ts),
        .clr_en    (clr_en),
        .clr_idx   (best_idx_reg)
    );

    assign rd_en    = (state_reg == S_SCAN) && (scan_reg != CNT_W'(SLOTS));
    assign out_free = !m_valid_reg || m_ready;

    // Snapshot order is by value descending, then slot index ascending.
    assign qual = rd_valid && (rd_ts < in_reg.bound) &&
                  (first_reg || (rd_ts < prev_v_reg) ||
                   ((rd_ts == prev_v_reg) && (eidx_reg > prev_idx_reg)));

    always_comb begin
        state_next    = state_reg;
        in_next       = in_reg;
        scan_next     = scan_reg;
        pend_next     = rd_en;
        eidx_next     = scan_reg[IDX_W-1:0];
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_v_next   = best_v_reg;
        cnt_next      = cnt_reg;
        prev_v_next   = prev_v_reg;
        prev_idx_next = prev_idx_reg;
        first_next    = first_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        clr_en        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    scan_next   = '0;
                    found_next  = 1'b0;
                    cnt_next    = '0;
                    first_next  = 1'b1;
                    best_v_next = TS_ALL_ONES;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    case (in_reg.action)
                        ACT_INSERT: begin
                            if (!rd_valid && !found_reg) begin
                                found_next    = 1'b1;
                                best_idx_next = eidx_reg;
                            end
                        end
                        ACT_REMOVE: begin
                            if (rd_valid && (rd_handle == in_reg.handle) && !found_reg) begin
                                found_next    = 1'b1;
                                best_idx_next = eidx_reg;
                            end
                        end
                        ACT_SNAPSHOT: begin
                            if (qual) begin
                                cnt_next = cnt_reg + CNT_W'(1);
                                if (!found_reg || (rd_ts > best_v_reg)) begin
                                    found_next    = 1'b1;
                                    best_v_next   = rd_ts;
                                    best_idx_next = eidx_reg;
                                end
                            end
                        end
                        default: begin
                            if (rd_valid && (rd_ts < best_v_reg)) begin
                                best_v_next = rd_ts;
                            end
                        end
                    endcase
                end else if (scan_reg == CNT_W'(SLOTS)) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    out_next.status    = ST_OK;
                    out_next.txn_id    = '0;
                    out_next.ts_value  = '0;
                    out_next.empty_res = 1'b0;
                    out_next.last      = 1'b1;
                    state_next         = S_IDLE;
                    case (in_reg.action)
                        ACT_INSERT: begin
                            if (found_reg) begin
                                out_next.txn_id = in_reg.global_id;
                                wr_en           = 1'b1;
                            end else begin
                                out_next.status = ST_FULL;
                            end
                        end
                        ACT_REMOVE: begin
                            if (found_reg) begin
                                clr_en = 1'b1;
                            end else begin
                                out_next.status = ST_NOT_FOUND;
                            end
                        end
                        ACT_SNAPSHOT: begin
                            if (!found_reg) begin
                                out_next.ts_value  = TS_ALL_ONES;
                                out_next.empty_res = 1'b1;
                            end else begin
                                out_next.ts_value = best_v_reg;
                                out_next.last     = (cnt_reg == CNT_W'(1));
                                if (cnt_reg != CNT_W'(1)) begin
                                    // advance past this element and rescan
                                    prev_v_next   = best_v_reg;
                                    prev_idx_next = best_idx_reg;
                                    first_next    = 1'b0;
                                    found_next    = 1'b0;
                                    cnt_next      = '0;
                                    scan_next     = '0;
                                    state_next    = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            out_next.ts_value = best_v_reg;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        scan_reg     <= scan_next;
        eidx_reg     <= eidx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_v_reg   <= best_v_next;
        cnt_reg      <= cnt_next;
        prev_v_reg   <= prev_v_next;
        prev_idx_reg <= prev_idx_next;
        first_reg    <= first_next;
        out_reg      <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- rtl/att_checker.sv -----
`timescale 1ns / 1ps

module att_checker
    import att_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after input transfer");

    // ready returns only once the final result of the item is loaded
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> (m_valid && m_data.last))
        else $error("ready returned without a final result");

    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.empty_res || (m_data.status != ST_OK)))
            |-> (m_data.last && (m_data.txn_id == 64'd0)))
        else $error("empty or error result not final or has an id");

endmodule

bind active_transaction_table_top att_checker u_att_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import att_pkg::*;

    localparam int NSLOT       = SLOTS_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = NSLOT + 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    active_transaction_table_top #(
        .SLOTS(NSLOT)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // Shadow copy of the slot table
    logic        mirror_valid  [NSLOT];
    logic [15:0] mirror_handle [NSLOT];
    logic [63:0] mirror_ts     [NSLOT];

    out_item_t pending_results [$];
    int        mismatch_cnt = 0;
    bit        idle_on      = 1'b1;
    int        rx_hold      = 0;
    int        quiet_cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic out_item_t make_result(input logic [1:0] st, input logic [63:0] id,
                                              input logic [63:0] ts, input logic emp,
                                              input logic lst);
        out_item_t r;
        r.status    = st;
        r.txn_id    = id;
        r.ts_value  = ts;
        r.empty_res = emp;
        r.last      = lst;
        return r;
    endfunction

    function automatic in_item_t make_op(input logic [1:0] act, input logic [15:0] hdl,
                                         input logic [63:0] ts, input logic [63:0] gid,
                                         input logic [63:0] bnd);
        in_item_t op;
        op.action    = act;
        op.handle    = hdl;
        op.read_ts   = ts;
        op.global_id = gid;
        op.bound     = bnd;
        return op;
    endfunction

    // Update the shadow table and queue the results one operation produces
    function automatic void predict_table_op(input in_item_t op);
        logic [63:0] hits [$];
        logic [63:0] swap;
        logic [63:0] lowest;
        int          slot;
        int          i;
        int          j;
        slot = -1;
        case (op.action)
            ACT_INSERT: begin
                for (i = 0; i < NSLOT; i++)
                    if (slot < 0 && !mirror_valid[i]) slot = i;
                if (slot >= 0) begin
                    mirror_valid[slot]  = 1'b1;
                    mirror_handle[slot] = op.handle;
                    mirror_ts[slot]     = op.read_ts;
                    pending_results.push_back(make_result(ST_OK, op.global_id, '0, 1'b0, 1'b1));
                end else begin
                    pending_results.push_back(make_result(ST_FULL, '0, '0, 1'b0, 1'b1));
                end
            end
            ACT_REMOVE: begin
                for (i = 0; i < NSLOT; i++)
                    if (slot < 0 && mirror_valid[i] && mirror_handle[i] == op.handle) slot = i;
                if (slot >= 0) begin
                    mirror_valid[slot] = 1'b0;
                    pending_results.push_back(make_result(ST_OK, '0, '0, 1'b0, 1'b1));
                end else begin
                    pending_results.push_back(make_result(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1));
                end
            end
            ACT_SNAPSHOT: begin
                for (i = 0; i < NSLOT; i++)
                    if (mirror_valid[i] && mirror_ts[i] < op.bound) hits.push_back(mirror_ts[i]);
                // largest first
                for (i = 1; i < hits.size(); i++) begin
                    for (j = i; j > 0 && hits[j - 1] < hits[j]; j--) begin
                        swap        = hits[j];
                        hits[j]     = hits[j - 1];
                        hits[j - 1] = swap;
                    end
                end
                if (hits.size() == 0) begin
                    pending_results.push_back(make_result(ST_OK, '0, TS_ALL_ONES, 1'b1, 1'b1));
                end else begin
                    for (i = 0; i < hits.size(); i++)
                        pending_results.push_back(make_result(ST_OK, '0, hits[i], 1'b0,
                                                              i == hits.size() - 1));
                end
            end
            default: begin
                lowest = TS_ALL_ONES;
                for (i = 0; i < NSLOT; i++)
                    if (mirror_valid[i] && mirror_ts[i] < lowest) lowest = mirror_ts[i];
                pending_results.push_back(make_result(ST_OK, '0, lowest, 1'b0, 1'b1));
            end
        endcase
    endfunction

    task automatic issue_op(input in_item_t op);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
        predict_table_op(op);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int live_slot();
        int live [$];
        int i;
        for (i = 0; i < NSLOT; i++)
            if (mirror_valid[i]) live.push_back(i);
        if (live.size() == 0) return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [15:0] pick_handle();
        // small pool forces duplicate handles
        if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 7));
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] pick_ts();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TS_ALL_ONES;
            2, 3:    return 64'($urandom_range(0, 63));
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] pick_bound();
        int slot;
        slot = live_slot();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TS_ALL_ONES;
            2, 3:    return (slot >= 0) ? mirror_ts[slot] + $urandom_range(0, 1) : pick_ts();
            default: return pick_ts();
        endcase
    endfunction

    task automatic test_empty_table();
        issue_op(make_op(ACT_HWM, 16'h0000, rand64(), rand64(), rand64()));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, rand64(), rand64(), TS_ALL_ONES));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, rand64(), rand64(), '0));
        issue_op(make_op(ACT_REMOVE, 16'h0000, rand64(), rand64(), rand64()));
    endtask

    task automatic test_extremes_and_duplicates();
        issue_op(make_op(ACT_INSERT, 16'h0000, '0, '0, rand64()));
        issue_op(make_op(ACT_INSERT, 16'hFFFF, TS_ALL_ONES, TS_ALL_ONES, '0));
        issue_op(make_op(ACT_INSERT, 16'h1234, 64'd5, 64'hA5A5_5A5A_0F0F_F0F0, TS_ALL_ONES));
        issue_op(make_op(ACT_INSERT, 16'h1234, 64'd5, 64'h5A5A_A5A5_F0F0_0F0F, '0));
        // all-ones timestamp is never strictly below any bound
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, TS_ALL_ONES));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, 64'd5));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, 64'd6));
        issue_op(make_op(ACT_HWM, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'h1234, '0, '0, '0));
        issue_op(make_op(ACT_INSERT, 16'h0007, 64'd9, rand64(), '0));
        issue_op(make_op(ACT_REMOVE, 16'hFFFF, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'hFFFF, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_HWM, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'h1234, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'h0007, '0, '0, '0));
        issue_op(make_op(ACT_HWM, 16'h0000, '0, '0, '0));
        // occupied table whose only timestamp is all ones
        issue_op(make_op(ACT_INSERT, 16'hBEEF, TS_ALL_ONES, rand64(), '0));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, TS_ALL_ONES));
        issue_op(make_op(ACT_HWM, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'hBEEF, '0, '0, '0));
    endtask

    task automatic test_fill_to_capacity();
        int n;
        int slot;
        n = 0;
        while (live_slot() < 0 || n < NSLOT) begin
            issue_op(make_op(ACT_INSERT, 16'h8000 | 16'(n), pick_ts(), rand64(), rand64()));
            n++;
        end
        issue_op(make_op(ACT_INSERT, 16'h0042, rand64(), rand64(), rand64()));
        issue_op(make_op(ACT_INSERT, 16'hFFFF, TS_ALL_ONES, TS_ALL_ONES, TS_ALL_ONES));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, TS_ALL_ONES));
        issue_op(make_op(ACT_SNAPSHOT, 16'h0000, '0, '0, pick_bound()));
        issue_op(make_op(ACT_HWM, 16'h0000, '0, '0, '0));
        issue_op(make_op(ACT_REMOVE, 16'h7FFF, '0, '0, '0));
        // drain in random order
        slot = live_slot();
        while (slot >= 0) begin
            issue_op(make_op(ACT_REMOVE, mirror_handle[slot], rand64(), rand64(), rand64()));
            if ($urandom_range(0, 7) == 0)
                issue_op(make_op(ACT_HWM, pick_handle(), rand64(), rand64(), rand64()));
            slot = live_slot();
        end
    endtask

    task automatic test_random_mix(input int count);
        in_item_t op;
        int       kind;
        int       slot;
        int       n;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            op   = make_op(ACT_HWM, pick_handle(), pick_ts(), rand64(), pick_bound());
            if (kind < 38) begin
                op.action = ACT_INSERT;
            end else if (kind < 65) begin
                op.action = ACT_REMOVE;
                slot = live_slot();
                if (slot >= 0) op.handle = mirror_handle[slot];
            end else if (kind < 70) begin
                op.action = ACT_REMOVE;
            end else if (kind < 85) begin
                op.action = ACT_SNAPSHOT;
            end
            issue_op(op);
        end
    endtask

    task automatic finish_run();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    endtask

    // Random back-pressure on the result channel
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("unexpected result: status=%0d txn_id=%h ts=%h empty=%b last=%b",
                             m_data.status, m_data.txn_id, m_data.ts_value,
                             m_data.empty_res, m_data.last);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status || m_data.txn_id !== want.txn_id ||
                    m_data.ts_value !== want.ts_value || m_data.empty_res !== want.empty_res ||
                    m_data.last !== want.last) begin
                    if (mismatch_cnt < 10) begin
                        $display("mismatch: expected status=%0d txn_id=%h ts=%h empty=%b last=%b",
                                 want.status, want.txn_id, want.ts_value,
                                 want.empty_res, want.last);
                        $display("          actual   status=%0d txn_id=%h ts=%h empty=%b last=%b",
                                 m_data.status, m_data.txn_id, m_data.ts_value,
                                 m_data.empty_res, m_data.last);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    // Abort when neither channel moves a transfer for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            mirror_valid[i]  = 1'b0;
            mirror_handle[i] = '0;
            mirror_ts[i]     = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_extremes_and_duplicates();
        test_fill_to_capacity();
        test_random_mix(55);
        idle_on = 1'b0;
        test_random_mix(25);
        finish_run();
    end

endmodule
